// ----- rtl/weighted_column_sum_filter_defines.svh -----
// Assertion macros used by the weighted column sum filter RTL.
`ifndef WEIGHTED_COLUMN_SUM_FILTER_DEFINES_SVH
`define WEIGHTED_COLUMN_SUM_FILTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WCSF_ASSERT_NOW(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WCSF_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/wcsf_pkg.sv -----
// Package with the types, codes and sizes of the weighted column sum filter.
package wcsf_pkg;

	// Column storage; the column field reaches 1024 columns.
	localparam int COLUMN_COUNT = 1024;
	localparam int ADDR_W = $clog2(COLUMN_COUNT);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(COLUMN_COUNT - 1);

	localparam int COUNT_W = 32;
	localparam int SUM_W = 64;

	// Request kinds.
	localparam logic [1:0] KIND_ROW_START = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;
	localparam logic [1:0] KIND_RESTART = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] row_weight;
		logic [9:0] column;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [9:0] column_out;
		logic [63:0] weighted_sum;
		logic kept;
	} out_item_t;

endpackage

// ----- rtl/wcsf_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
module wcsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/weighted_column_sum_filter.sv -----
// Weighted column sum filter: per-column weighted tallies of sparse rows with read-and-clear
// reports. After reset the block sweeps both column memories to zero, one column per cycle;
// in_stall stays high during the sweep while configuration writes are taken. After that it
// accepts one request per clock cycle. In its first stage a request reads the column
// memories and forms the weight-times-value product; in the second it adds, saturates and
// writes back, with the last write forwarded so that back-to-back requests to one column
// see each other. A report's result is loaded into the output register when its second
// stage completes; only a report that finds the output register full and stalled holds
// the pipeline.
// The keep threshold may be written at any time the block is idle; cfg_ready is always high.
`include "weighted_column_sum_filter_defines.svh"

module weighted_column_sum_filter (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input wcsf_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output wcsf_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data
);
	import wcsf_pkg::*;

	// Configuration and running weights.
	logic [31:0] min_hits_q;
	logic [31:0] total_weight_q;
	logic [31:0] current_weight_q;

	// Reset sweep.
	logic clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Second stage.
	logic s1_valid_q;
	logic [1:0] kind_s1;
	logic [9:0] column_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic in_range_s1;
	logic [COUNT_W-1:0] weight_s1;
	logic [SUM_W-1:0] prod_s1;

	// Last write back, forwarded to the next read of the same column.
	logic fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [COUNT_W-1:0] fwd_hit_q;
	logic [SUM_W-1:0] fwd_sum_q;

	// Output register.
	logic out_valid_q;
	out_item_t out_q;

	// Memory ports.
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [COUNT_W-1:0] hit_wdata;
	logic [SUM_W-1:0] sum_wdata;
	logic [COUNT_W-1:0] hit_rdata;
	logic [SUM_W-1:0] sum_rdata;
	logic [ADDR_W-1:0] in_addr;

	// Stage control and datapath.
	logic accept;
	logic out_free;
	logic s1_report;
	logic s1_done;
	logic s1_write;
	logic use_fwd;
	logic [COUNT_W-1:0] hit_old;
	logic [SUM_W-1:0] sum_old;
	logic [COUNT_W:0] hit_add;
	logic [SUM_W:0] sum_add;
	logic [COUNT_W-1:0] hit_new;
	logic [SUM_W-1:0] sum_new;
	logic [31:0] threshold;
	logic [32:0] total_add;

	// Handshake.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_report = kind_s1 == KIND_REPORT;
	assign s1_done = s1_valid_q && (!s1_report || out_free);
	assign in_stall = clearing_q || (s1_valid_q && !s1_done);
	assign accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign in_addr = ADDR_W'(in_data.column);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hits_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			min_hits_q <= cfg_data;
		end
	end

	// Row weights are handled at acceptance.
	assign total_add = {1'b0, total_weight_q} + {1'b0, in_data.row_weight};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_weight_q <= '0;
			current_weight_q <= '0;
		end else if (accept) begin
			unique case (in_data.kind)
				KIND_ROW_START: begin
					current_weight_q <= in_data.row_weight;
					total_weight_q <= total_add[32] ? '1 : total_add[31:0];
				end
				KIND_RESTART: begin
					total_weight_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Reset sweep that zeroes every column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// First stage: read issue and product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= in_data.kind;
			column_s1 <= in_data.column;
			addr_s1 <= in_addr;
			in_range_s1 <= 32'(in_data.column) < 32'(COLUMN_COUNT);
			weight_s1 <= current_weight_q;
			prod_s1 <= 64'(current_weight_q) * 64'(in_data.value);
		end
	end

	wcsf_ram #(.WIDTH(COUNT_W), .DEPTH(COLUMN_COUNT)) u_hit_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(hit_wdata),
		.re(accept),
		.raddr(in_addr),
		.rdata(hit_rdata)
	);

	wcsf_ram #(.WIDTH(SUM_W), .DEPTH(COLUMN_COUNT)) u_sum_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(sum_wdata),
		.re(accept),
		.raddr(in_addr),
		.rdata(sum_rdata)
	);

	// Second stage: forward, add with saturation, write back.
	assign use_fwd = fwd_valid_q && (fwd_addr_q == addr_s1);
	assign hit_old = use_fwd ? fwd_hit_q : hit_rdata;
	assign sum_old = use_fwd ? fwd_sum_q : sum_rdata;
	assign hit_add = {1'b0, hit_old} + {1'b0, weight_s1};
	assign sum_add = {1'b0, sum_old} + {1'b0, prod_s1};
	assign s1_write = s1_done && in_range_s1 && (kind_s1 == KIND_ENTRY || s1_report);
	assign threshold = (min_hits_q == '0) ? 32'd1 : min_hits_q;

	always_comb begin
		if (s1_report) begin
			hit_new = '0;
			sum_new = '0;
		end else begin
			hit_new = hit_add[COUNT_W] ? '1 : hit_add[COUNT_W-1:0];
			sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
		end
	end

	// The sweep owns the write port until it ends.
	always_comb begin
		if (clearing_q) begin
			ram_we = 1'b1;
			ram_waddr = clr_addr_q;
			hit_wdata = '0;
			sum_wdata = '0;
		end else begin
			ram_we = s1_write;
			ram_waddr = addr_s1;
			hit_wdata = hit_new;
			sum_wdata = sum_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_write) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_write) begin
			fwd_addr_q <= addr_s1;
			fwd_hit_q <= hit_new;
			fwd_sum_q <= sum_new;
		end
	end

	// Output register for report results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done && s1_report) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && s1_report) begin
			out_q.column_out <= column_s1;
			out_q.weighted_sum <= in_range_s1 ? sum_old : '0;
			out_q.kept <= in_range_s1 && (hit_old >= threshold) && (total_weight_q >= threshold);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// No request may reach the write-back stage during the reset sweep.
	`WCSF_ASSERT_NOW(a_no_item_while_clearing, clk, arst_n, clearing_q, !s1_valid_q,
		"request in flight during the reset sweep")

	// A report facing a full, stalled output register must hold the input side.
	`WCSF_ASSERT_NOW(a_report_interlock, clk, arst_n,
		s1_valid_q && s1_report && out_valid_q && out_stall, in_stall,
		"report overran a stalled result")

	// Each write back is captured for forwarding.
	`WCSF_ASSERT_NEXT(a_forward_capture, clk, arst_n, s1_write && !clearing_q,
		fwd_valid_q && (fwd_addr_q == $past(addr_s1)),
		"write back not captured for forwarding")

endmodule
